### src/ssf_pkg.sv
`timescale 1ns / 1ps

package ssf_pkg;

    // Build-time sizes
    localparam int DEF_MAX_SUBS    = 64;
    localparam int DEF_MAX_COLS    = 256;
    localparam int DEF_MAX_CONTRIB = 8;

    // Quarter-wave cosine ROM geometry
    localparam int COS_TABLE_SIZE = 256;
    localparam int COS_N2         = 2 * COS_TABLE_SIZE;
    localparam int PW             = $clog2(COS_N2 + 1);
    localparam int RIW            = $clog2(COS_TABLE_SIZE + 1);
    localparam int ONE_Q16        = 65536;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Request kinds
    localparam logic [1:0] REQ_LOAD_CENTER = 2'd0;
    localparam logic [1:0] REQ_LOAD_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_COMPUTE     = 2'd2;
    localparam logic [1:0] REQ_RESERVED    = 2'd3;

    // Register indexes
    localparam logic [2:0] CFG_INV_RANGE   = 3'd0;
    localparam logic [2:0] CFG_HALF_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_BAND_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_CENTER_OFF  = 3'd3;
    localparam logic [2:0] CFG_TAPER_START = 3'd4;
    localparam logic [2:0] CFG_MAX_CONTRIB = 3'd5;
    localparam logic [2:0] CFG_SUBS_USED   = 3'd6;
    localparam logic [2:0] CFG_COLS_USED   = 3'd7;

    // Divider jobs
    localparam logic [1:0] DIV_COL   = 2'd0;
    localparam logic [1:0] DIV_WRAP  = 2'd1;
    localparam logic [1:0] DIV_TAPER = 2'd2;

    typedef logic [16:0] cos_rom_t [0:COS_TABLE_SIZE];

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       write_mem;
        logic       div_start;
        logic [1:0] div_mode;
        logic       col_latch;
        logic       mul_latch;
        logic       wrap_latch;
        logic       scan_start;
        logic       scan_step;
        logic       term_dist;
        logic       term_psel;
        logic       term_pdiv;
        logic       term_weight;
        logic       term_mac;
        logic       term_acc;
        logic       out_load;
    } ssf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       div_busy;
        logic       band_zero;
        logic       scan_done;
        logic       term_end;
        logic       need_div;
    } ssf_status_t;

    // Series cosine in Q16 of an angle in Q30 radians
    function automatic logic [16:0] cos_q16(input logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] term;
        longint      sum;
        int          k;
        a2   = (a * a) >> 30;
        term = 64'd1 << 30;
        sum  = longint'(term);
        for (k = 1; k <= 10; k++)
        begin
            term = ((term * a2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if ((k % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        return 17'((sum + 8192) >>> 14);
    endfunction

    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        int       j;
        for (j = 0; j <= COS_TABLE_SIZE; j++)
            rom[j] = cos_q16((HALF_PI_Q30 * 64'(j)) / 64'(COS_TABLE_SIZE));
        rom[0] = 17'(ONE_Q16);
        return rom;
    endfunction

endpackage

### src/subaperture_spectrum_fusion_core.sv
`timescale 1ns / 1ps

// Subaperture spectrum fusion for one wavenumber row. Load items store a
// subaperture center or one complex spectrum sample and are answered by an
// acknowledge with is_result low; compute items return the taper-weighted,
// saturated sum of up to max_contrib spectra at column fine_index mod
// cols_used. Items are handled one at a time. A load captures the item,
// writes the memory and answers. A compute runs the column modulo, the band
// wrap (skipped when band_width is zero), the center scan through the table
// port and then each term, with a divide per term on the taper ramp, paced
// by the single shared one-bit-a-cycle divider and the one-read memory ports;
// a stalled result adds its stall.
// Memories are not cleared; read only entries that were loaded.

module subaperture_spectrum_fusion_core
    import ssf_pkg::*;
#(
    parameter int MAX_SUBS    = DEF_MAX_SUBS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_CONTRIB = DEF_MAX_CONTRIB
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // sub_index, column, fine_index, value, sample_re, sample_im, zero pad
    input  logic [111:0] s_tdata,
    // req_type
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_re, out_im
    output logic [63:0]  m_tdata,
    // is_result
    output logic         m_tuser
);

    ssf_cmd_t    cmd;
    ssf_status_t status;

    ssf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssf_datapath #(
        .MAX_SUBS    (MAX_SUBS),
        .MAX_COLS    (MAX_COLS),
        .MAX_CONTRIB (MAX_CONTRIB)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### src/ssf_ctrl.sv
`timescale 1ns / 1ps

module ssf_ctrl
    import ssf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  ssf_status_t status,
    output ssf_cmd_t    cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_LOAD   = 5'd1;
    localparam logic [4:0] S_MOD    = 5'd2;
    localparam logic [4:0] S_MODW   = 5'd3;
    localparam logic [4:0] S_MUL    = 5'd4;
    localparam logic [4:0] S_WRAP   = 5'd5;
    localparam logic [4:0] S_WRAPW  = 5'd6;
    localparam logic [4:0] S_WFIX   = 5'd7;
    localparam logic [4:0] S_SCAN0  = 5'd8;
    localparam logic [4:0] S_SCAN   = 5'd9;
    localparam logic [4:0] S_TCHECK = 5'd10;
    localparam logic [4:0] S_TDIST  = 5'd11;
    localparam logic [4:0] S_TPSEL  = 5'd12;
    localparam logic [4:0] S_TWAIT  = 5'd13;
    localparam logic [4:0] S_TW     = 5'd14;
    localparam logic [4:0] S_TMAC   = 5'd15;
    localparam logic [4:0] S_TACC   = 5'd16;
    localparam logic [4:0] S_RESP   = 5'd17;

    logic [4:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign out_free = !mvalid_reg || m_tready;

    // Sequence one item through the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_mode = DIV_COL;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.write_mem = 1'b1;
                if (status.req_type == REQ_COMPUTE)
                    state_next = S_MOD;
                else
                    state_next = S_RESP;
            end
            S_MOD:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mode  = DIV_COL;
                state_next    = S_MODW;
            end
            S_MODW:
            begin
                if (!status.div_busy)
                begin
                    cmd.col_latch = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_latch = 1'b1;
                state_next    = S_WRAP;
            end
            S_WRAP:
            begin
                if (status.band_zero)
                    state_next = S_WFIX;
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_mode  = DIV_WRAP;
                    state_next    = S_WRAPW;
                end
            end
            S_WRAPW:
            begin
                if (!status.div_busy)
                    state_next = S_WFIX;
            end
            S_WFIX:
            begin
                cmd.wrap_latch = 1'b1;
                state_next     = S_SCAN0;
            end
            S_SCAN0:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                    state_next = S_TCHECK;
            end
            S_TCHECK:
            begin
                if (status.term_end)
                    state_next = S_RESP;
                else
                    state_next = S_TDIST;
            end
            S_TDIST:
            begin
                cmd.term_dist = 1'b1;
                state_next    = S_TPSEL;
            end
            S_TPSEL:
            begin
                cmd.term_psel = 1'b1;
                if (status.need_div)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_mode  = DIV_TAPER;
                    state_next    = S_TWAIT;
                end
                else
                    state_next = S_TW;
            end
            S_TWAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.term_pdiv = 1'b1;
                    state_next    = S_TW;
                end
            end
            S_TW:
            begin
                cmd.term_weight = 1'b1;
                state_next      = S_TMAC;
            end
            S_TMAC:
            begin
                cmd.term_mac = 1'b1;
                state_next   = S_TACC;
            end
            S_TACC:
            begin
                cmd.term_acc = 1'b1;
                state_next   = S_TCHECK;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result until it is taken
    always_comb
    begin
        mvalid_next = mvalid_reg;
        if (m_tready)
            mvalid_next = 1'b0;
        if (cmd.out_load)
            mvalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

### src/ssf_datapath.sv
`timescale 1ns / 1ps

module ssf_datapath
    import ssf_pkg::*;
#(
    parameter int MAX_SUBS    = DEF_MAX_SUBS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_CONTRIB = DEF_MAX_CONTRIB
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic [111:0] s_tdata,
    input  logic [1:0]   s_tuser,
    input  ssf_cmd_t     cmd,
    output ssf_status_t  status,
    output logic [63:0]  m_tdata,
    output logic         m_tuser
);

    localparam int SW  = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NSW = $clog2(MAX_SUBS + 1);
    localparam int KW  = $clog2(MAX_CONTRIB + 1);
    localparam int UW  = NSW + KW;
    localparam int SPEC_DEPTH = MAX_SUBS * (1 << CW);
    localparam cos_rom_t COS_ROM = build_cos_rom();

    // Configuration registers
    logic [30:0]        inv_reg, hw_reg, band_reg, ts_reg;
    logic signed [31:0] co_reg;
    logic [3:0]         mc_reg;
    logic [6:0]         su_reg;
    logic [8:0]         cu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg  <= 31'd65536;
            hw_reg   <= 31'd65536;
            band_reg <= 31'd65536;
            co_reg   <= 32'sd0;
            ts_reg   <= 31'd0;
            mc_reg   <= 4'd4;
            su_reg   <= 7'd64;
            cu_reg   <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INV_RANGE:   inv_reg  <= cfg_data[30:0];
                CFG_HALF_WIDTH:  hw_reg   <= cfg_data[30:0];
                CFG_BAND_WIDTH:  band_reg <= cfg_data[30:0];
                CFG_CENTER_OFF:  co_reg   <= cfg_data;
                CFG_TAPER_START: ts_reg   <= cfg_data[30:0];
                CFG_MAX_CONTRIB: mc_reg   <= cfg_data[3:0];
                CFG_SUBS_USED:   su_reg   <= cfg_data[6:0];
                CFG_COLS_USED:   cu_reg   <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    // Captured item
    logic [1:0]         req_reg;
    logic [5:0]         sub_reg;
    logic [7:0]         colin_reg;
    logic [15:0]        fine_reg;
    logic signed [31:0] val_reg;
    logic [47:0]        smp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= s_tuser;
            sub_reg   <= s_tdata[5:0];
            colin_reg <= s_tdata[13:6];
            fine_reg  <= s_tdata[29:14];
            val_reg   <= s_tdata[61:30];
            smp_reg   <= s_tdata[109:62];
        end
    end

    // Effective counts
    logic [8:0]     sub9, su9;
    logic [10:0]    col11, cu11, nc11;
    logic [4:0]     mc5;
    logic [NSW-1:0] ns;
    logic [KW-1:0]  nk;
    logic           sub_ok, col_ok;

    assign sub9   = {3'b0, sub_reg};
    assign col11  = {3'b0, colin_reg};
    assign su9    = {2'b0, su_reg};
    assign cu11   = {2'b0, cu_reg};
    assign mc5    = {1'b0, mc_reg};
    assign sub_ok = sub9 < 9'(MAX_SUBS);
    assign col_ok = col11 < 11'(MAX_COLS);
    assign ns     = (su9 > 9'(MAX_SUBS)) ? NSW'(MAX_SUBS) : NSW'(su9);
    assign nk     = (mc5 > 5'(MAX_CONTRIB)) ? KW'(MAX_CONTRIB) : KW'(mc5);
    assign nc11   = (cu11 == 11'd0) ? 11'd1 :
                    ((cu11 > 11'(MAX_COLS)) ? 11'(MAX_COLS) : cu11);

    // Position arithmetic
    logic signed [63:0] prod;
    logic signed [47:0] xeq_reg, xw_reg, off48, diff, xw_next;
    logic [47:0]        mag;
    logic               wneg_reg;
    logic [30:0]        rfix;

    assign prod  = $signed(val_reg) * $signed({1'b0, inv_reg});
    assign off48 = {{16{co_reg[31]}}, co_reg} - $signed({18'b0, band_reg[30:1]});
    assign diff  = xeq_reg - off48;
    assign mag   = diff[47] ? 48'(-diff) : 48'(diff);

    // Iterative restoring divider, one bit a cycle
    logic [30:0] rem_reg, dvs_reg;
    logic [47:0] sh_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [31:0] dtrial;
    logic        dge;
    logic [47:0] tnum;
    logic [30:0] span;
    logic signed [49:0] d_reg;

    assign span   = hw_reg - ts_reg;
    assign tnum   = 48'(d_reg[30:0]) * 48'(COS_N2) + 48'(span[30:1]);
    assign dtrial = {rem_reg, sh_reg[47]};
    assign dge    = dtrial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else if (cmd.div_start)
        begin
            busy_reg <= 1'b1;
            case (cmd.div_mode)
                DIV_COL:   cnt_reg <= 6'd16;
                DIV_WRAP:  cnt_reg <= 6'd48;
                default:   cnt_reg <= 6'(PW);
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            case (cmd.div_mode)
                DIV_COL:
                begin
                    dvs_reg <= {20'b0, nc11};
                    rem_reg <= 31'd0;
                    sh_reg  <= {fine_reg, 32'b0};
                end
                DIV_WRAP:
                begin
                    dvs_reg  <= band_reg;
                    rem_reg  <= 31'd0;
                    sh_reg   <= mag;
                    wneg_reg <= diff[47];
                end
                default:
                begin
                    dvs_reg <= span;
                    rem_reg <= 31'(tnum >> PW);
                    sh_reg  <= tnum << (48 - PW);
                end
            endcase
        end
        else if (busy_reg)
        begin
            rem_reg <= dge ? 31'(dtrial - {1'b0, dvs_reg}) : dtrial[30:0];
            sh_reg  <= {sh_reg[46:0], dge};
        end
    end

    // Column, scaled position and wrapped position
    logic [CW-1:0] col_reg;

    assign rfix    = (wneg_reg && (rem_reg != 31'd0)) ? (band_reg - rem_reg) : rem_reg;
    assign xw_next = (band_reg == 31'd0) ? xeq_reg : ($signed({17'b0, rfix}) + off48);

    always_ff @(posedge clk)
    begin
        if (cmd.col_latch)
            col_reg <= rem_reg[CW-1:0];
        if (cmd.mul_latch)
            xeq_reg <= 48'(prod >>> 16);
        if (cmd.wrap_latch)
            xw_reg <= xw_next;
    end

    // Center table and spectrum store
    logic [31:0]         center_mem [0:MAX_SUBS-1];
    logic [47:0]         spec_mem   [0:SPEC_DEPTH-1];
    logic signed [31:0]  center_rd_reg;
    logic [47:0]         spec_rd_reg;
    logic [NSW-1:0]      i_reg, u0_reg;
    logic [KW-1:0]       k_reg;
    logic [UW-1:0]       u;
    logic [SW-1:0]       caddr;
    logic                cmp_v_reg;

    assign u     = UW'(u0_reg) + UW'(k_reg);
    assign caddr = cmd.scan_step ? i_reg[SW-1:0] : u[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.write_mem && (req_reg == REQ_LOAD_CENTER) && sub_ok)
            center_mem[sub9[SW-1:0]] <= val_reg;
        center_rd_reg <= center_mem[caddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_mem && (req_reg == REQ_LOAD_SAMPLE) && sub_ok && col_ok)
            spec_mem[{sub9[SW-1:0], col11[CW-1:0]}] <= smp_reg;
        spec_rd_reg <= spec_mem[{u[SW-1:0], col_reg}];
    end

    // Count centers below the search value
    logic signed [48:0] lo;
    logic               below;

    assign lo    = {xw_reg[47], xw_reg} - $signed({18'b0, hw_reg});
    assign below = $signed({{17{center_rd_reg[31]}}, center_rd_reg}) < lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmp_v_reg <= 1'b0;
        else if (cmd.scan_start)
            cmp_v_reg <= 1'b0;
        else if (cmd.scan_step)
            cmp_v_reg <= (i_reg < ns);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            i_reg  <= '0;
            u0_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (i_reg < ns)
                i_reg <= i_reg + NSW'(1);
            if (cmp_v_reg && below)
                u0_reg <= u0_reg + NSW'(1);
        end
    end

    // Weighted gather of the contributing spectra
    logic signed [48:0] cdiff;
    logic [48:0]        cdist, dist_reg;
    logic               taper_mode;
    logic [PW-1:0]      p_reg, pm;
    logic [RIW-1:0]     ridx;
    logic [16:0]        rom_q, w_reg;
    logic [17:0]        wsum;
    logic signed [41:0] pre_re_reg, pre_im_reg;
    logic signed [47:0] acc_re_reg, acc_im_reg;

    assign cdiff      = {xw_reg[47], xw_reg} - {{17{center_rd_reg[31]}}, center_rd_reg};
    assign cdist      = cdiff[48] ? 49'(-cdiff) : 49'(cdiff);
    assign taper_mode = hw_reg > ts_reg;
    assign pm         = PW'(COS_N2) - p_reg;
    assign ridx       = (p_reg <= PW'(COS_TABLE_SIZE)) ? p_reg[RIW-1:0] : pm[RIW-1:0];
    assign rom_q      = COS_ROM[ridx];
    assign wsum       = (p_reg <= PW'(COS_TABLE_SIZE)) ? (18'(ONE_Q16) + {1'b0, rom_q}) :
                                                        (18'(ONE_Q16) - {1'b0, rom_q});

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            k_reg      <= '0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        if (cmd.term_dist)
        begin
            dist_reg <= cdist;
            d_reg    <= $signed({1'b0, cdist}) - $signed({19'b0, ts_reg});
        end
        if (cmd.term_psel)
            p_reg <= (d_reg <= 50'sd0) ? PW'(0) : PW'(COS_N2);
        if (cmd.term_pdiv)
            p_reg <= sh_reg[PW-1:0];
        if (cmd.term_weight)
        begin
            if (taper_mode)
                w_reg <= wsum[17:1];
            else
                w_reg <= (dist_reg <= {18'b0, hw_reg}) ? 17'(ONE_Q16) : 17'd0;
        end
        if (cmd.term_mac)
        begin
            pre_re_reg <= $signed({1'b0, w_reg}) * $signed(spec_rd_reg[23:0]);
            pre_im_reg <= $signed({1'b0, w_reg}) * $signed(spec_rd_reg[47:24]);
        end
        if (cmd.term_acc)
        begin
            acc_re_reg <= acc_re_reg + 48'(pre_re_reg);
            acc_im_reg <= acc_im_reg + 48'(pre_im_reg);
            k_reg      <= k_reg + KW'(1);
        end
    end

    // Round, saturate and register the result
    logic signed [48:0] rnd_re, rnd_im;
    logic signed [32:0] sh_re, sh_im;
    logic [31:0]        sat_re, sat_im;
    logic [31:0]        ore_reg, oim_reg;
    logic               isr_reg;

    assign rnd_re = {acc_re_reg[47], acc_re_reg} + 49'sd32768;
    assign rnd_im = {acc_im_reg[47], acc_im_reg} + 49'sd32768;
    assign sh_re  = 33'(rnd_re >>> 16);
    assign sh_im  = 33'(rnd_im >>> 16);
    assign sat_re = (sh_re > 33'sd2147483647) ? 32'h7FFFFFFF :
                    ((sh_re < -33'sd2147483648) ? 32'h80000000 : sh_re[31:0]);
    assign sat_im = (sh_im > 33'sd2147483647) ? 32'h7FFFFFFF :
                    ((sh_im < -33'sd2147483648) ? 32'h80000000 : sh_im[31:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (req_reg == REQ_COMPUTE)
            begin
                ore_reg <= sat_re;
                oim_reg <= sat_im;
                isr_reg <= 1'b1;
            end
            else
            begin
                ore_reg <= 32'd0;
                oim_reg <= 32'd0;
                isr_reg <= 1'b0;
            end
        end
    end

    assign m_tdata = {oim_reg, ore_reg};
    assign m_tuser = isr_reg;

    // Status back to the controller
    assign status.req_type  = req_reg;
    assign status.div_busy  = busy_reg;
    assign status.band_zero = (band_reg == 31'd0);
    assign status.scan_done = (i_reg >= ns) && !cmp_v_reg;
    assign status.term_end  = (k_reg >= nk) || (u >= UW'(ns));
    assign status.need_div  = taper_mode && (d_reg > 50'sd0) &&
                              (d_reg < $signed({19'b0, span}));

endmodule

### dv/tb_subaperture_spectrum_fusion_core.sv
`timescale 1ns / 1ps

module tb_subaperture_spectrum_fusion_core;
    import ssf_pkg::*;

    localparam int NSUB = 64;
    localparam int NCOL = 256;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        is_res;
    } fused_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [111:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    subaperture_spectrum_fusion_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state
    logic [16:0]  cos_tab [0:COS_TABLE_SIZE];
    logic [31:0]  ctr_tab [0:NSUB-1];
    logic [23:0]  spec_re [0:NSUB*NCOL-1];
    logic [23:0]  spec_im [0:NSUB*NCOL-1];
    logic [30:0]  r_inv, r_half, r_band, r_taper;
    logic [31:0]  r_off;
    logic [3:0]   r_maxc;
    logic [6:0]   r_subs;
    logic [8:0]   r_cols;

    fused_t fused_q[$];
    int     n_err;
    int     n_cmp;
    int     n_fused;
    bit     stim_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("tb_subaperture_spectrum_fusion_core: errors");
        $finish;
    end

    // Build cosine ROM independently in a fixed-point integer series
    function automatic longint cos_series(longint unsigned a);
        longint unsigned a2, trm;
        longint          acc;
        int              k;
        a2  = (a * a) >> 30;
        trm = 64'd1 << 30;
        acc = longint'(trm);
        for (k = 1; k <= 10; k++)
        begin
            trm = ((trm * a2) >> 30) / longint'((2 * k - 1) * (2 * k));
            acc = (k % 2 == 1) ? acc - longint'(trm) : acc + longint'(trm);
        end
        if (acc < 0)
            acc = 0;
        return (acc + 8192) >>> 14;
    endfunction

    function automatic longint floor_div_q16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint taper_weight(longint sep);
        longint span, d, p;
        if (r_half > r_taper)
        begin
            span = longint'(r_half) - longint'(r_taper);
            d = sep - longint'(r_taper);
            if (d <= 0)
                p = 0;
            else if (d >= span)
                p = 2 * COS_TABLE_SIZE;
            else
                p = (d * 2 * COS_TABLE_SIZE + span / 2) / span;
            if (p <= COS_TABLE_SIZE)
                return (65536 + longint'(cos_tab[p])) >>> 1;
            return (65536 - longint'(cos_tab[2 * COS_TABLE_SIZE - p])) >>> 1;
        end
        return (sep <= longint'(r_half)) ? 65536 : 0;
    endfunction

    function automatic logic [31:0] sat_round(longint acc);
        longint v;
        v = (acc + 32768) >>> 16;
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Work out the fused sample for one compute item
    function automatic fused_t fuse_predict(logic [15:0] fine, logic [31:0] val);
        fused_t  f;
        int      ns, nk, nc, col, u0, u;
        longint  off, x, r, lo, sep, w, are, aim;
        ns  = (r_subs > NSUB) ? NSUB : r_subs;
        nk  = (r_maxc > 8) ? 8 : r_maxc;
        nc  = (r_cols == 0) ? 1 : ((r_cols > NCOL) ? NCOL : r_cols);
        col = int'(fine) % nc;
        off = longint'($signed(r_off)) - longint'(r_band >> 1);
        x   = floor_div_q16(longint'($signed(val)) * longint'(r_inv));
        if (r_band != 0)
        begin
            r = (x - off) % longint'(r_band);
            if (r < 0)
                r += longint'(r_band);
            x = r + off;
        end
        lo = x - longint'(r_half);
        u0 = 0;
        for (int i = 0; i < ns; i++)
            if (longint'($signed(ctr_tab[i])) < lo)
                u0++;
        are = 0;
        aim = 0;
        for (int k = 0; k < nk; k++)
        begin
            u = u0 + k;
            if (u >= ns)
                break;
            sep = x - longint'($signed(ctr_tab[u]));
            if (sep < 0)
                sep = -sep;
            w = taper_weight(sep);
            are += w * longint'($signed(spec_re[u * NCOL + col]));
            aim += w * longint'($signed(spec_im[u * NCOL + col]));
        end
        f.re = sat_round(are);
        f.im = sat_round(aim);
        f.is_res = 1'b1;
        return f;
    endfunction

    // Send one item and record what it should produce
    task automatic send_item(logic [1:0] kind, logic [5:0] sub, logic [7:0] col,
                             logic [15:0] fine, logic [31:0] val,
                             logic [23:0] sre, logic [23:0] sim);
        fused_t f;
        int     gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        repeat (gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'd0, sim, sre, val, fine, col, sub};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        s_tvalid <= 1'b0;
        f = '0;
        case (kind)
            REQ_LOAD_CENTER: ctr_tab[sub] = val;
            REQ_LOAD_SAMPLE:
            begin
                spec_re[sub * NCOL + col] = sre;
                spec_im[sub * NCOL + col] = sim;
            end
            REQ_COMPUTE: f = fuse_predict(fine, val);
            default: ;
        endcase
        fused_q.push_back(f);
        // the block is busy after taking an item
        @(posedge clk);
    endtask

    // Wait until every expected result has come back
    task automatic drain;
        while (fused_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_INV_RANGE:   r_inv   = data[30:0];
            CFG_HALF_WIDTH:  r_half  = data[30:0];
            CFG_BAND_WIDTH:  r_band  = data[30:0];
            CFG_CENTER_OFF:  r_off   = data;
            CFG_TAPER_START: r_taper = data[30:0];
            CFG_MAX_CONTRIB: r_maxc  = data[3:0];
            CFG_SUBS_USED:   r_subs  = data[6:0];
            default:         r_cols  = data[8:0];
        endcase
        @(posedge clk);
    endtask

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    // Fill every center in sorted order; samples are loaded separately
    task automatic load_tables(int spacing);
        logic [31:0] c;
        c = -32 * spacing;
        for (int s = 0; s < NSUB; s++)
        begin
            send_item(REQ_LOAD_CENTER, 6'(s), 8'd0, 16'(rnd32()), c,
                      24'd0, 24'd0);
            c = c + spacing + $urandom_range(0, spacing / 4);
        end
    endtask

    task automatic load_column_set(int ncols);
        for (int s = 0; s < NSUB; s++)
            for (int k = 0; k < ncols; k++)
                send_item(REQ_LOAD_SAMPLE, 6'(s), 8'(k), 16'(rnd32()),
                          rnd32(), 24'(rnd32()), 24'(rnd32()));
    endtask

    task automatic compute_burst(int n, int ncols, int span);
        logic [31:0] v;
        for (int i = 0; i < n; i++)
        begin
            v = 32'($urandom_range(0, 2 * span)) - 32'(span);
            if ($urandom_range(0, 9) == 0)
                v = rnd32();
            send_item(REQ_COMPUTE, 6'(rnd32()), 8'(rnd32()), 16'(rnd32()), v,
                      24'(rnd32()), 24'(rnd32()));
        end
    endtask

    // Directed: table fill, extreme samples, unknown kind, zero band width
    task automatic test_directed;
        load_tables(65536);
        load_column_set(2);
        drain();
        write_reg(CFG_COLS_USED, 32'd2);
        drain();
        send_item(REQ_LOAD_SAMPLE, 6'd63, 8'd1, 16'hFFFF, 32'h8000_0000,
                  24'h7FFFFF, 24'h800000);
        send_item(REQ_LOAD_SAMPLE, 6'd0, 8'd0, 16'h0, 32'h7FFF_FFFF,
                  24'h800000, 24'h7FFFFF);
        send_item(REQ_RESERVED, 6'd5, 8'd1, 16'h1234, 32'h0, 24'h0, 24'h0);
        send_item(REQ_COMPUTE, 6'd0, 8'd0, 16'hFFFF, 32'h0, 24'h0, 24'h0);
        send_item(REQ_COMPUTE, 6'd0, 8'd0, 16'h0, 32'h7FFF_FFFF, 24'h0, 24'h0);
        send_item(REQ_COMPUTE, 6'd0, 8'd0, 16'h1, 32'h8000_0000, 24'h0, 24'h0);
        drain();
        write_reg(CFG_BAND_WIDTH, 32'd0);
        write_reg(CFG_HALF_WIDTH, 32'd200000);
        write_reg(CFG_MAX_CONTRIB, 32'd8);
        drain();
        compute_burst(6, 2, 32 * 65536);
        drain();
    endtask

    // Sweep settings including extremes, random computes under each
    task automatic test_settings;
        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            write_reg(CFG_INV_RANGE, (ph == 0) ? 32'h7FFF_FFFF :
                      32'($urandom_range(30000, 100000)));
            write_reg(CFG_HALF_WIDTH, (ph == 1) ? 32'h7FFF_FFFF :
                      32'($urandom_range(0, 300000)));
            write_reg(CFG_BAND_WIDTH, (ph == 2) ? 32'd1 : (ph == 3) ? 32'h7FFF_FFFF :
                      32'($urandom_range(0, 1 << 23)));
            write_reg(CFG_CENTER_OFF, (ph == 4) ? 32'h8000_0000 : (ph == 5) ?
                      32'h7FFF_FFFF : 32'($urandom_range(0, 1 << 20)) - 32'h80000);
            write_reg(CFG_TAPER_START, (ph == 6) ? 32'h7FFF_FFFF :
                      32'($urandom_range(0, 150000)));
            write_reg(CFG_MAX_CONTRIB, (ph == 7) ? 32'd15 : (ph == 8) ? 32'd0 :
                      32'($urandom_range(1, 8)));
            write_reg(CFG_SUBS_USED, (ph == 8) ? 32'd0 : (ph == 9) ? 32'd127 :
                      32'($urandom_range(1, 64)));
            write_reg(CFG_COLS_USED, (ph == 9) ? 32'd0 : 32'($urandom_range(1, 2)));
            compute_burst(70, 2, 40 * 65536);
            if (ph == 5)
            begin
                // hold off until every result has come back
                drain();
                load_tables(20000 + $urandom_range(0, 100000));
            end
        end
        drain();
    endtask

    // Wide columns, cols_used written at maximum, then computes folded to four
    task automatic test_wide_columns;
        load_column_set(4);
        drain();
        write_reg(CFG_COLS_USED, 32'd256);
        write_reg(CFG_MAX_CONTRIB, 32'd8);
        write_reg(CFG_SUBS_USED, 32'd64);
        drain();
        // samples everywhere at columns 4..255 for a few subs is too many, so fold
        write_reg(CFG_COLS_USED, 32'd4);
        compute_burst(100, 4, 40 * 65536);
        drain();
    endtask

    initial
    begin
        for (int j = 0; j <= COS_TABLE_SIZE; j++)
            cos_tab[j] = 17'(cos_series((64'd1686629713 * j) / COS_TABLE_SIZE));
        cos_tab[0] = 17'd65536;
        r_inv = 65536; r_half = 65536; r_band = 65536; r_off = 0; r_taper = 0;
        r_maxc = 4; r_subs = 64; r_cols = 256;
        n_err = 0; n_cmp = 0; n_fused = 0; stim_done = 1'b0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_wide_columns();
        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d results, %0d of them computes, over ten register phases",
                 n_cmp, n_fused);
        $display("with load, unknown and compute kinds plus range and setting extremes");
        if (n_err == 0 && fused_q.size() == 0)
            $display("tb_subaperture_spectrum_fusion_core: clean");
        else
            $display("tb_subaperture_spectrum_fusion_core: errors");
        $finish;
    end

    // Result side: random stall, compare with oldest expectation
    initial
    begin
        fused_t e;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 3) != 0)
                repeat ($urandom_range(0, 11)) @(posedge clk);
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            m_tready <= 1'b0;
            n_cmp++;
            if (fused_q.size() == 0)
            begin
                n_err++;
                $display("%t unexpected item %h %b", $time, m_tdata, m_tuser);
            end
            else
            begin
                e = fused_q.pop_front();
                if (e.is_res)
                    n_fused++;
                if (m_tdata[31:0] !== e.re)
                begin
                    n_err++;
                    $display("%t out_re exp %h got %h", $time, e.re, m_tdata[31:0]);
                end
                if (m_tdata[63:32] !== e.im)
                begin
                    n_err++;
                    $display("%t out_im exp %h got %h", $time, e.im, m_tdata[63:32]);
                end
                if (m_tuser !== e.is_res)
                begin
                    n_err++;
                    $display("%t is_result exp %b got %b", $time, e.is_res, m_tuser);
                end
            end
            // ready is low here, so a further result waits for the next loop
            @(posedge clk);
        end
    end

endmodule
